// ===== sv/sdtq_pkg.sv =====
// package for the sorted deadline timer queue: codes, types and defaults
`default_nettype none
package sdtq_pkg;
	localparam int SLOTS_DEF = 16;
	localparam int TIME_BITS_DEF = 32;
	localparam int ID_W = 4;
	localparam int NUM_IDS = 16;
	localparam int TAG_W = 32;
	localparam int FIELD_W = 32;

	typedef enum logic [1:0] {
		CMD_ADD = 2'd0,
		CMD_DEL = 2'd1,
		CMD_ADJ = 2'd2,
		CMD_TICK = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_OK = 3'd0,
		ST_FULL = 3'd1,
		ST_DUP = 3'd2,
		ST_INACTIVE = 3'd3,
		ST_EARLIER = 3'd4
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECIDE,
		S_FIND_RD,
		S_FIND_CHK,
		S_REM_RD,
		S_REM_WR,
		S_INS_RD,
		S_INS_CHK,
		S_INS_WR,
		S_TICK_RD,
		S_TICK_CHK,
		S_TICK_EMIT
	} state_t;
endpackage
`default_nettype wire

// ===== sv/sdtq_order_ram.sv =====
// order memory: handles in deadline order, one write and one registered read port
`default_nettype none
module sdtq_order_ram #(
	parameter int SLOTS = sdtq_pkg::SLOTS_DEF,
	localparam int AW = $clog2(SLOTS)
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [AW-1:0] waddr,
	input wire logic [sdtq_pkg::ID_W-1:0] wdata,
	input wire logic [AW-1:0] raddr,
	output logic [sdtq_pkg::ID_W-1:0] rdata
);
	logic [sdtq_pkg::ID_W-1:0] mem [SLOTS];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// ===== sv/sdtq_slot_ram.sv =====
// per-handle memory: deadline and tag, one write and one registered read port
`default_nettype none
module sdtq_slot_ram #(
	parameter int TIME_BITS = sdtq_pkg::TIME_BITS_DEF
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [sdtq_pkg::ID_W-1:0] waddr,
	input wire logic [TIME_BITS-1:0] wdl,
	input wire logic [sdtq_pkg::TAG_W-1:0] wtag,
	input wire logic [sdtq_pkg::ID_W-1:0] raddr,
	output logic [TIME_BITS-1:0] rdl,
	output logic [sdtq_pkg::TAG_W-1:0] rtag
);
	logic [TIME_BITS-1:0] dl_mem [sdtq_pkg::NUM_IDS];
	logic [sdtq_pkg::TAG_W-1:0] tag_mem [sdtq_pkg::NUM_IDS];

	always_ff @(posedge clk) begin
		if (we) begin
			dl_mem[waddr] <= wdl;
			tag_mem[waddr] <= wtag;
		end
		rdl <= dl_mem[raddr];
		rtag <= tag_mem[raddr];
	end
endmodule
`default_nettype wire

// ===== sv/sorted_deadline_timer_queue.sv =====
// top level of the sorted deadline timer queue: command sequencer around two memories
// A request is taken when start is high and busy is low. Results come out one per cycle at
// most, each marked by valid for one cycle, with last on the final one of a request. The
// receiver cannot stall. The order list lives in a memory that is walked one entry at a time.
// An add walks the list from the tail, shifting entries up until the new one is placed. A
// delete searches from the head and shifts the later entries down; an adjust does the same
// and then inserts anew. A tick removes each expired timer from the head and stops at an
// empty list or at a timer that is still live. A rejected command ends in the decide state.
// A status result shows in the same cycle that busy falls.
// No clearing pass after reset: only state, active bits, entry count, valid and pend_q reset.
`default_nettype none
module sorted_deadline_timer_queue #(
	parameter int SLOTS = sdtq_pkg::SLOTS_DEF,
	parameter int TIME_BITS = sdtq_pkg::TIME_BITS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	output logic busy,
	input wire logic [1:0] cmd,
	input wire logic [3:0] timer_id,
	input wire logic [31:0] deadline,
	input wire logic [31:0] now_time,
	input wire logic [31:0] user_tag,
	output logic valid,
	output logic kind,
	output logic [2:0] status,
	output logic [3:0] expired_id,
	output logic [31:0] expired_tag,
	output logic last
);
	localparam int AW = $clog2(SLOTS);
	localparam int CW = $clog2(SLOTS + 1);
	localparam int IW = sdtq_pkg::ID_W;
	localparam int FW = sdtq_pkg::FIELD_W;
	localparam int TW = TIME_BITS;
	localparam int DW = (TW < FW) ? TW : FW;

	sdtq_pkg::state_t state_q, state_d;
	sdtq_pkg::cmd_t cmd_q;
	logic [IW-1:0] id_q;
	logic [TW-1:0] dl_q, now_q;
	logic [sdtq_pkg::TAG_W-1:0] tag_q;
	logic [sdtq_pkg::NUM_IDS-1:0] active_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] pos_q;
	logic [IW-1:0] prev_id_q;
	logic ins_place_q;
	logic pend_q;
	logic [IW-1:0] pend_id_q;
	logic [sdtq_pkg::TAG_W-1:0] pend_tag_q;

	logic o_we;
	logic [AW-1:0] o_waddr, o_raddr;
	logic [IW-1:0] o_wdata, o_rdata;
	logic s_we;
	logic [IW-1:0] s_raddr;
	logic [TW-1:0] s_rdl;
	logic [sdtq_pkg::TAG_W-1:0] s_rtag;

	logic [TW-1:0] dl_in, now_in;

	always_comb begin
		dl_in = '0;
		now_in = '0;
		dl_in[DW-1:0] = deadline[DW-1:0];
		now_in[DW-1:0] = now_time[DW-1:0];
	end

	sdtq_order_ram #(.SLOTS(SLOTS)) u_order (
		.clk(clk), .we(o_we), .waddr(o_waddr), .wdata(o_wdata),
		.raddr(o_raddr), .rdata(o_rdata)
	);

	sdtq_slot_ram #(.TIME_BITS(TIME_BITS)) u_slot (
		.clk(clk), .we(s_we), .waddr(id_q), .wdl(dl_q), .wtag(tag_q),
		.raddr(s_raddr), .rdl(s_rdl), .rtag(s_rtag)
	);

	// pos_q as an address, pos_q-1 and pos_q+1 likewise
	logic [AW-1:0] pos_a, pos_m1_a, pos_p1_a;
	logic [CW-1:0] pos_m1, pos_p1;
	assign pos_m1 = pos_q - CW'(1);
	assign pos_p1 = pos_q + CW'(1);
	assign pos_a = pos_q[AW-1:0];
	assign pos_m1_a = pos_m1[AW-1:0];
	assign pos_p1_a = pos_p1[AW-1:0];

	logic tick_done;
	assign tick_done = (count_q == '0);

	// insert: walk from the tail, shifting while the entry's deadline is above the new one
	// INS_RD reads order[pos-1], INS_CHK fetches its deadline, INS_WR shifts or places
	logic ins_shift, ins_place;
	logic [TW-1:0] tick_now;
	logic tick_hit;
	assign ins_shift = (s_rdl > dl_q);
	assign ins_place = ins_place_q || !ins_shift;
	assign tick_now = now_q;
	assign tick_hit = !(s_rdl > tick_now);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			sdtq_pkg::S_IDLE:
				if (start)
					state_d = (sdtq_pkg::cmd_t'(cmd) == sdtq_pkg::CMD_TICK)
						? sdtq_pkg::S_TICK_RD : sdtq_pkg::S_DECIDE;
			sdtq_pkg::S_DECIDE: begin
				state_d = sdtq_pkg::S_IDLE;
				if (cmd_q == sdtq_pkg::CMD_ADD) begin
					if (!active_q[id_q] && count_q < CW'(SLOTS))
						state_d = sdtq_pkg::S_INS_RD;
				end else if (active_q[id_q]) begin
					if (cmd_q == sdtq_pkg::CMD_DEL || !(dl_q < s_rdl))
						state_d = sdtq_pkg::S_FIND_RD;
				end
			end
			sdtq_pkg::S_FIND_RD: state_d = sdtq_pkg::S_FIND_CHK;
			sdtq_pkg::S_FIND_CHK:
				state_d = (o_rdata == id_q) ? sdtq_pkg::S_REM_RD : sdtq_pkg::S_FIND_RD;
			sdtq_pkg::S_REM_RD:
				if (pos_p1 < count_q)
					state_d = sdtq_pkg::S_REM_WR;
				else if (cmd_q == sdtq_pkg::CMD_ADJ)
					state_d = sdtq_pkg::S_INS_RD;
				else if (cmd_q == sdtq_pkg::CMD_TICK)
					state_d = sdtq_pkg::S_TICK_RD;
				else
					state_d = sdtq_pkg::S_IDLE;
			sdtq_pkg::S_REM_WR: state_d = sdtq_pkg::S_REM_RD;
			sdtq_pkg::S_INS_RD:
				state_d = (pos_q == '0) ? sdtq_pkg::S_INS_WR : sdtq_pkg::S_INS_CHK;
			sdtq_pkg::S_INS_CHK: state_d = sdtq_pkg::S_INS_WR;
			sdtq_pkg::S_INS_WR:
				state_d = ins_place ? sdtq_pkg::S_IDLE : sdtq_pkg::S_INS_RD;
			sdtq_pkg::S_TICK_RD:
				state_d = tick_done ? sdtq_pkg::S_IDLE : sdtq_pkg::S_TICK_CHK;
			sdtq_pkg::S_TICK_CHK: state_d = sdtq_pkg::S_TICK_EMIT;
			sdtq_pkg::S_TICK_EMIT:
				state_d = tick_hit ? sdtq_pkg::S_REM_RD : sdtq_pkg::S_IDLE;
			default: state_d = sdtq_pkg::S_IDLE;
		endcase
	end

	// outputs and memory controls
	always_comb begin
		o_we = 1'b0;
		o_waddr = pos_a;
		o_wdata = id_q;
		o_raddr = pos_a;
		s_we = 1'b0;
		s_raddr = id_q;
		busy = (state_q != sdtq_pkg::S_IDLE);
		unique case (state_q)
			sdtq_pkg::S_IDLE: s_raddr = timer_id;
			sdtq_pkg::S_REM_RD: o_raddr = pos_p1_a;
			sdtq_pkg::S_REM_WR: begin
				o_we = 1'b1;
				o_wdata = o_rdata;
			end
			sdtq_pkg::S_INS_RD: o_raddr = pos_m1_a;
			sdtq_pkg::S_INS_CHK: s_raddr = o_rdata;
			sdtq_pkg::S_INS_WR: begin
				o_we = 1'b1;
				o_wdata = ins_place ? id_q : prev_id_q;
				s_we = ins_place;
			end
			sdtq_pkg::S_TICK_RD: o_raddr = '0;
			sdtq_pkg::S_TICK_CHK: s_raddr = o_rdata;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sdtq_pkg::S_IDLE;
			active_q <= '0;
			count_q <= '0;
			valid <= 1'b0;
			pend_q <= 1'b0;
		end else begin
			state_q <= state_d;
			valid <= 1'b0;
			unique case (state_q)
				sdtq_pkg::S_IDLE:
					if (start)
						pend_q <= 1'b0;
				sdtq_pkg::S_DECIDE: begin
					if (cmd_q == sdtq_pkg::CMD_ADD && !active_q[id_q]
						&& count_q < CW'(SLOTS)) begin
						active_q[id_q] <= 1'b1;
					end
					if (state_d == sdtq_pkg::S_IDLE)
						valid <= 1'b1;
				end
				sdtq_pkg::S_REM_RD:
					if (!(pos_p1 < count_q)) begin
						count_q <= count_q - CW'(1);
						if (cmd_q == sdtq_pkg::CMD_DEL) begin
							active_q[id_q] <= 1'b0;
							valid <= 1'b1;
						end
					end
				sdtq_pkg::S_INS_WR:
					if (ins_place) begin
						count_q <= count_q + CW'(1);
						valid <= 1'b1;
					end
				sdtq_pkg::S_TICK_RD:
					if (tick_done && pend_q)
						valid <= 1'b1;
				sdtq_pkg::S_TICK_EMIT: begin
					if (pend_q)
						valid <= 1'b1;
					if (tick_hit) begin
						active_q[prev_id_q] <= 1'b0;
						pend_q <= 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			sdtq_pkg::S_IDLE:
				if (start) begin
					cmd_q <= sdtq_pkg::cmd_t'(cmd);
					id_q <= timer_id;
					dl_q <= dl_in;
					now_q <= now_in;
					tag_q <= user_tag;
					pos_q <= '0;
				end
			sdtq_pkg::S_DECIDE: begin
				pos_q <= (cmd_q == sdtq_pkg::CMD_ADD) ? count_q : '0;
				if (cmd_q == sdtq_pkg::CMD_ADJ)
					tag_q <= s_rtag;
				kind <= 1'b0;
				expired_id <= id_q;
				expired_tag <= '0;
				last <= 1'b1;
				if (cmd_q == sdtq_pkg::CMD_ADD)
					status <= active_q[id_q] ? sdtq_pkg::ST_DUP
						: (count_q < CW'(SLOTS) ? sdtq_pkg::ST_OK : sdtq_pkg::ST_FULL);
				else if (!active_q[id_q])
					status <= sdtq_pkg::ST_INACTIVE;
				else if (cmd_q == sdtq_pkg::CMD_ADJ && dl_q < s_rdl)
					status <= sdtq_pkg::ST_EARLIER;
				else
					status <= sdtq_pkg::ST_OK;
			end
			sdtq_pkg::S_FIND_CHK:
				if (o_rdata != id_q)
					pos_q <= pos_p1;
			sdtq_pkg::S_REM_RD:
				if (!(pos_p1 < count_q))
					pos_q <= count_q - CW'(1);
			sdtq_pkg::S_REM_WR: pos_q <= pos_p1;
			sdtq_pkg::S_INS_RD:
				ins_place_q <= (pos_q == '0);
			sdtq_pkg::S_INS_CHK:
				prev_id_q <= o_rdata;
			sdtq_pkg::S_INS_WR:
				if (!ins_place)
					pos_q <= pos_m1;
			sdtq_pkg::S_TICK_RD: begin
				pos_q <= '0;
				if (tick_done) begin
					kind <= 1'b1;
					status <= sdtq_pkg::ST_OK;
					expired_id <= pend_id_q;
					expired_tag <= pend_tag_q;
					last <= 1'b1;
				end
			end
			sdtq_pkg::S_TICK_CHK:
				prev_id_q <= o_rdata;
			sdtq_pkg::S_TICK_EMIT: begin
				kind <= 1'b1;
				status <= sdtq_pkg::ST_OK;
				expired_id <= pend_id_q;
				expired_tag <= pend_tag_q;
				last <= !tick_hit;
				if (tick_hit) begin
					pend_id_q <= prev_id_q;
					pend_tag_q <= s_rtag;
				end
			end
			default: ;
		endcase
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(SLOTS));
	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !kind |-> last);
	a_valid_busy: assert property (@(posedge clk) disable iff (!arst_n)
		valid |-> $past(busy));
	a_idle_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == sdtq_pkg::S_IDLE |-> CW'($countones(active_q)) == count_q);
`endif
endmodule
`default_nettype wire
